// ----- rtl/core/extent_bitmap_allocator_top_macros.svh -----
// Assertion macros shared by the allocator top level.
`ifndef EXTENT_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define EXTENT_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extent bitmap allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("extent bitmap allocator check failed");

`endif

// ----- rtl/core/ebm_pkg.sv -----
package ebm_pkg;

  localparam int MAP_BITS    = 4096;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = MAP_BITS / WORD_BITS;
  localparam int WADDR_W     = $clog2(MAP_WORDS);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int IDX_W       = 12;
  localparam int CNT_W       = 7;
  localparam int MAX_REQUEST = 64;
  localparam int BUF_AW      = $clog2(MAX_REQUEST);
  localparam int BASE_W      = 31;
  localparam int NUM_W       = 32;

  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] extent_index;
    logic [CNT_W-1:0] requested_count;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0] extent_number;
    logic             found;
    logic [CNT_W-1:0] allocated_so_far;
    logic             last;
    logic             tail_in_use;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_WR,
    ST_SCAN,
    ST_OUT_RD,
    ST_OUT_EMIT,
    ST_EMIT_NONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic rel_write;
    logic scan;
    logic out_first;
    logic out_emit;
    logic emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic got_zero;
    logic out_last;
  } dp_status_t;

endpackage

// ----- rtl/core/ebm_ctrl.sv -----
module ebm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                command_i,
  input  ebm_pkg::dp_status_t status_i,
  output logic                busy,
  output ebm_pkg::dp_cmd_t    cmd_o
);

  ebm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ebm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d = (command_i == ebm_pkg::CMD_RELEASE) ? ebm_pkg::ST_REL_WR
                                                         : ebm_pkg::ST_SCAN;
        end
      end
      ebm_pkg::ST_REL_WR: begin
        cmd_o.rel_write = 1'b1;
        state_d = ebm_pkg::ST_EMIT_NONE;
      end
      ebm_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = status_i.got_zero ? ebm_pkg::ST_EMIT_NONE : ebm_pkg::ST_OUT_RD;
        end
      end
      ebm_pkg::ST_OUT_RD: begin
        cmd_o.out_first = 1'b1;
        state_d = ebm_pkg::ST_OUT_EMIT;
      end
      ebm_pkg::ST_OUT_EMIT: begin
        cmd_o.out_emit = 1'b1;
        if (status_i.out_last) begin
          state_d = ebm_pkg::ST_IDLE;
        end
      end
      ebm_pkg::ST_EMIT_NONE: begin
        cmd_o.emit_none = 1'b1;
        state_d = ebm_pkg::ST_IDLE;
      end
      default: begin
        state_d = ebm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/ebm_datapath.sv -----
module ebm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ebm_pkg::dp_cmd_t                  cmd_i,
  input  ebm_pkg::req_t                     req_i,
  input  logic                              cfg_we_i,
  input  logic [ebm_pkg::BASE_W-1:0]        cfg_data_i,
  output ebm_pkg::dp_status_t               status_o,
  output ebm_pkg::rsp_t                     rsp_o
);

  localparam int WORD_BITS = ebm_pkg::WORD_BITS;
  localparam int WADDR_W   = ebm_pkg::WADDR_W;
  localparam int BIT_W     = ebm_pkg::BIT_W;
  localparam int IDX_W     = ebm_pkg::IDX_W;
  localparam int CNT_W     = ebm_pkg::CNT_W;
  localparam int BUF_AW    = ebm_pkg::BUF_AW;

  logic [WORD_BITS-1:0] map_mem [ebm_pkg::MAP_WORDS];
  logic [ebm_pkg::MAP_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rd_valid_q;

  logic [IDX_W-1:0] buf_mem [ebm_pkg::MAX_REQUEST];
  logic [IDX_W-1:0] buf_rdata_q;
  logic [BUF_AW-1:0] buf_raddr;
  logic             buf_re;

  logic [ebm_pkg::BASE_W-1:0] base_q;
  logic                       tail_free_q;
  logic [IDX_W-1:0]           cursor_q;
  logic [IDX_W-1:0]           ext_q;
  logic [CNT_W-1:0]           want_q;
  logic [CNT_W-1:0]           got_q;
  logic [CNT_W-1:0]           out_ptr_q;
  logic [WADDR_W-1:0]         word_addr_q;
  logic [WORD_BITS-1:0]       word_q;
  logic [WORD_BITS-1:0]       cand_q;
  logic                       fresh_q;
  logic                       first_q;

  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] lowmask;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] cur_cand;
  logic [WORD_BITS-1:0] bitsel;
  logic [WORD_BITS-1:0] rel_word;
  logic [BIT_W-1:0]     pos;
  logic [IDX_W-1:0]     alloc_idx;
  logic [CNT_W-1:0]     want_sat;
  logic                 do_alloc;
  logic                 scan_done;

  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WADDR_W-1:0]   mem_raddr;

  assign rd_word  = rd_valid_q ? rdata_q : {WORD_BITS{1'b1}};
  assign lowmask  = {WORD_BITS{1'b1}} << cursor_q[BIT_W-1:0];
  assign cur_word = fresh_q ? rd_word : word_q;
  assign cur_cand = fresh_q ? (rd_word & (first_q ? lowmask : {WORD_BITS{1'b1}})) : cand_q;

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cur_cand[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign bitsel    = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
  assign alloc_idx = {word_addr_q, pos};
  assign do_alloc  = (cur_cand != '0) && (got_q < want_q);
  assign scan_done = !do_alloc &&
                     ((got_q == want_q) || (word_addr_q == WADDR_W'(ebm_pkg::MAP_WORDS - 1)));
  assign rel_word  = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << ext_q[BIT_W-1:0]);
  assign want_sat  = (req_i.requested_count > CNT_W'(ebm_pkg::MAX_REQUEST))
                     ? CNT_W'(ebm_pkg::MAX_REQUEST) : req_i.requested_count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_addr_q;
    mem_wdata = cur_word;
    if (cmd_i.rel_write) begin
      mem_we    = 1'b1;
      mem_waddr = ext_q[IDX_W-1:BIT_W];
      mem_wdata = rel_word;
    end else if (cmd_i.scan && !do_alloc) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = word_addr_q + WADDR_W'(1);
    if (cmd_i.accept) begin
      mem_re    = 1'b1;
      mem_raddr = (req_i.command == ebm_pkg::CMD_RELEASE)
                  ? req_i.extent_index[IDX_W-1:BIT_W] : cursor_q[IDX_W-1:BIT_W];
    end else if (cmd_i.scan && !do_alloc && !scan_done) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  assign buf_re    = cmd_i.out_first || cmd_i.out_emit;
  assign buf_raddr = cmd_i.out_first ? '0 : (out_ptr_q[BUF_AW-1:0] + BUF_AW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && do_alloc) begin
      buf_mem[got_q[BUF_AW-1:0]] <= alloc_idx;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      base_q      <= '0;
      tail_free_q <= 1'b1;
      cursor_q    <= '0;
      got_q       <= '0;
      out_ptr_q   <= '0;
      fresh_q     <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_q <= valid_q[mem_raddr];
      end
      if (cmd_i.accept) begin
        got_q   <= '0;
        fresh_q <= 1'b1;
        first_q <= 1'b1;
      end
      if (cmd_i.rel_write && (ext_q == IDX_W'(ebm_pkg::MAP_BITS - 1))) begin
        tail_free_q <= 1'b1;
      end
      if (cmd_i.scan) begin
        if (do_alloc) begin
          got_q    <= got_q + CNT_W'(1);
          cursor_q <= alloc_idx;
          fresh_q  <= 1'b0;
          if (alloc_idx == IDX_W'(ebm_pkg::MAP_BITS - 1)) begin
            tail_free_q <= 1'b0;
          end
        end else if (!scan_done) begin
          fresh_q <= 1'b1;
          first_q <= 1'b0;
        end
      end
      if (cmd_i.out_first) begin
        out_ptr_q <= '0;
      end else if (cmd_i.out_emit) begin
        out_ptr_q <= out_ptr_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ext_q       <= req_i.extent_index;
      want_q      <= want_sat;
      word_addr_q <= cursor_q[IDX_W-1:BIT_W];
    end
    if (cmd_i.scan) begin
      if (do_alloc) begin
        word_q <= cur_word & ~bitsel;
        cand_q <= cur_cand & ~bitsel;
      end else if (!scan_done) begin
        word_addr_q <= word_addr_q + WADDR_W'(1);
      end
    end
  end

  assign status_o.scan_done = scan_done;
  assign status_o.got_zero  = (got_q == '0);
  assign status_o.out_last  = ((out_ptr_q + CNT_W'(1)) == got_q);

  always_comb begin
    rsp_o                  = '0;
    rsp_o.tail_in_use      = ~tail_free_q;
    rsp_o.last             = cmd_i.emit_none || status_o.out_last;
    if (cmd_i.out_emit) begin
      rsp_o.found            = 1'b1;
      rsp_o.extent_number    = {1'b0, base_q} +
                               {{(ebm_pkg::NUM_W-IDX_W){1'b0}}, buf_rdata_q};
      rsp_o.allocated_so_far = out_ptr_q + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/extent_bitmap_allocator_top.sv -----
// Release: ST_REL_WR sets the bit and ST_EMIT_NONE gives the single result; the word
// read-modify-write sets the rate. Allocate: ST_SCAN visits map words one per cycle, held on
// a word while extents are taken from it; then N results, or one when nothing is found.
// Results come one per cycle from the index buffer and cannot be stalled by the receiver.
// Reset is asynchronous and active low; the map reads as all free through per-word valid bits,
// so no clearing pass is needed and start is taken in the first cycle after reset.
`include "extent_bitmap_allocator_top_macros.svh"

module extent_bitmap_allocator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ebm_pkg::req_t              cmd_i,
  output logic                       result_valid_o,
  output ebm_pkg::rsp_t              result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ebm_pkg::BASE_W-1:0] cfg_data_i
);

  ebm_pkg::dp_cmd_t    dp_cmd;
  ebm_pkg::dp_status_t dp_status;

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = dp_cmd.out_emit || dp_cmd.emit_none;

  ebm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (cmd_i.command),
    .status_i  (dp_status),
    .busy      (busy),
    .cmd_o     (dp_cmd)
  );

  ebm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .req_i      (cmd_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .status_o   (dp_status),
    .rsp_o      (result_o)
  );

  `EBM_ASSERT_NOW(a_result_while_busy, clk_i, rst_ni, result_valid_o, busy)
  `EBM_ASSERT_NOW(a_empty_is_last, clk_i, rst_ni, result_valid_o && !result_o.found, result_o.last)
  `EBM_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, result_valid_o && result_o.last, !busy)
  `EBM_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)

endmodule

// ----- tb/tb_extent_bitmap_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_extent_bitmap_allocator_top;

  localparam int STALL_LIMIT = 4000;
  localparam int MAP_BITS    = ebm_pkg::MAP_BITS;
  localparam int IDX_W       = ebm_pkg::IDX_W;
  localparam int CNT_W       = ebm_pkg::CNT_W;
  localparam int BASE_W      = ebm_pkg::BASE_W;
  localparam int MAX_REQUEST = ebm_pkg::MAX_REQUEST;

  typedef struct {
    ebm_pkg::req_t req;
    bit            at_cursor;
  } pending_cmd_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  ebm_pkg::req_t cmd_i;
  logic result_valid_o;
  ebm_pkg::rsp_t result_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [BASE_W-1:0] cfg_data_i;

  pending_cmd_t pending_cmds[$];
  ebm_pkg::rsp_t expected_extents[$];

  bit [MAP_BITS-1:0] free_map;
  logic [IDX_W-1:0] scan_cursor;
  logic [BASE_W-1:0] extent_base;

  int idle_pct = 10;
  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int extents_granted = 0;
  int base_writes = 0;
  int errors = 0;
  int stall_cycles = 0;
  bit cmd_taken = 1'b0;
  bit base_taken = 1'b0;

  extent_bitmap_allocator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic predict_extents(input ebm_pkg::req_t r);
    ebm_pkg::rsp_t granted[$];
    ebm_pkg::rsp_t item;
    int want;
    bit tail_used;
    if (r.command == ebm_pkg::CMD_RELEASE) begin
      if (int'(r.extent_index) < MAP_BITS) free_map[r.extent_index] = 1'b1;
      item = '0;
      item.last = 1'b1;
      item.tail_in_use = !free_map[MAP_BITS-1];
      expected_extents.insert(expected_extents.size(), item);
      return;
    end
    want = (int'(r.requested_count) > MAX_REQUEST) ? MAX_REQUEST : int'(r.requested_count);
    for (int i = int'(scan_cursor); i < MAP_BITS && granted.size() < want; i++) begin
      if (free_map[i]) begin
        free_map[i] = 1'b0;
        scan_cursor = IDX_W'(i);
        item = '0;
        item.extent_number = 32'(extent_base) + 32'(i);
        item.found = 1'b1;
        item.allocated_so_far = CNT_W'(granted.size() + 1);
        granted.insert(granted.size(), item);
      end
    end
    tail_used = !free_map[MAP_BITS-1];
    if (granted.size() == 0) begin
      item = '0;
      item.last = 1'b1;
      granted.insert(granted.size(), item);
    end else begin
      granted[granted.size()-1].last = 1'b1;
    end
    foreach (granted[k]) begin
      granted[k].tail_in_use = tail_used;
      expected_extents.insert(expected_extents.size(), granted[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin : drive_commands
    pending_cmd_t job;
    if (rst_ni && (!start || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        job = pending_cmds.pop_front();
        if (job.at_cursor) begin
          // Releasing the cursor extent makes it visible to the next scan again.
          job.req.extent_index = (scan_cursor != '0 && $urandom_range(0, 3) == 0) ?
                                 scan_cursor - 1'b1 : scan_cursor;
        end
        cmd_i <= job.req;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_ports
    ebm_pkg::rsp_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (result_valid_o) begin
        moved = 1'b1;
        results_checked++;
        if (result_o.found) extents_granted++;
        if (expected_extents.size() == 0) begin
          errors++;
          $display("%0t: result expected none, actual %h", $time, result_o);
        end else begin
          want = expected_extents.pop_front();
          check_field("extent_number", want.extent_number, result_o.extent_number);
          check_field("found", 32'(want.found), 32'(result_o.found));
          check_field("allocated_so_far", 32'(want.allocated_so_far),
                      32'(result_o.allocated_so_far));
          check_field("last", 32'(want.last), 32'(result_o.last));
          check_field("tail_in_use", 32'(want.tail_in_use), 32'(result_o.tail_in_use));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        cmd_taken = 1'b1;
        items_accepted++;
        predict_extents(cmd_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        extent_base = cfg_data_i;
        base_taken = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  function automatic void queue_item(input logic command, input int index, input int count,
                                     input bit at_cursor);
    pending_cmd_t job;
    job.req.command = command;
    job.req.extent_index = IDX_W'(index);
    job.req.requested_count = CNT_W'(count);
    job.at_cursor = at_cursor;
    pending_cmds.insert(pending_cmds.size(), job);
    items_queued++;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_accepted != items_queued || expected_extents.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk_i);
    base_taken = 1'b0;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!base_taken);
    cfg_valid_i <= 1'b0;
    base_writes++;
  endtask

  task automatic queue_random(input int count);
    int pick;
    int want;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_item(ebm_pkg::CMD_RELEASE, $urandom_range(0, MAP_BITS - 1),
                   $urandom_range(0, 127), $urandom_range(0, 1));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) want = 0;
        else if (pick < 10) want = MAX_REQUEST;
        else if (pick < 15) want = $urandom_range(MAX_REQUEST + 1, 127);
        else want = $urandom_range(1, 16);
        queue_item(ebm_pkg::CMD_ALLOCATE, $urandom_range(0, MAP_BITS - 1), want, 1'b0);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    free_map = '1;
    scan_cursor = '0;
    extent_base = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 0, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 1, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 12'hFFF, MAX_REQUEST, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 127, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 128, 0, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 1, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 5, 127, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 2, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, MAP_BITS - 1, 0, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 0, 0, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 12'hAAA, 7'h2A, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 12'h555, 7'h55, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, MAX_REQUEST + 1, 1'b0);
    write_base({BASE_W{1'b1}});
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 3, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 2, 0, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 0, 1'b0);

    write_base(BASE_W'($urandom));
    idle_pct = 0;
    queue_random(130);
    write_base('0);
    idle_pct = 10;
    queue_random(135);
    write_base({BASE_W{1'b1}});
    queue_random(135);
    wait_drained();

    write_base(BASE_W'($urandom));
    for (int n = 0; n < 80 && free_map[MAP_BITS-1]; n++) begin
      queue_item(ebm_pkg::CMD_ALLOCATE, 0, MAX_REQUEST, 1'b0);
      wait_drained();
    end
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 5, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, MAP_BITS - 1, 0, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, MAX_REQUEST, 1'b0);
    queue_item(ebm_pkg::CMD_RELEASE, 100, 0, 1'b0);
    queue_item(ebm_pkg::CMD_ALLOCATE, 0, 1, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d commands and %0d results with %0d extents allocated.",
             items_accepted, results_checked, extents_granted);
    $display("Base offset written %0d times; map driven to full and released again.",
             base_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

endmodule
